// File: hdl/ptmt_pkg.sv
// ----------------------------------------------------------------------------
// ptmt_pkg - shared types and constants for the page table map/translate block
// Request and status codes, page geometry and the walker command and status.
// ----------------------------------------------------------------------------
package ptmt_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned PAGE_OFFSET_BITS = 12;
  localparam int unsigned VPN_W            = ADDR_W - PAGE_OFFSET_BITS;  // 20
  localparam int unsigned CNT_W            = VPN_W + 1;                  // holds 2^20
  localparam int unsigned FLAG_W           = 12;
  localparam int unsigned PCNT_W           = 11;
  localparam int unsigned STAT_W           = 2;

  // request codes
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_MAP    = 3'd1;
  localparam logic [2:0] REQ_MAP_TO = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_XLATE  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [VPN_W-1:0]  va_page;
    logic [VPN_W-1:0]  pa_page;
    logic [CNT_W-1:0]  count;
    logic [FLAG_W-1:0] flags;
  } walk_cmd_t;

  typedef struct packed {
    logic done;  // no pages left
    logic oob;   // current virtual page beyond the store
  } walk_stat_t;

endpackage

// File: hdl/ptmt_if.sv
// ----------------------------------------------------------------------------
// ptmt_if - request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptmt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] vaddr;
  logic [31:0] paddr;
  logic [31:0] paddr_end;
  logic [10:0] npages;
  logic [11:0] map_flags;

  modport source (output valid, req_type, vaddr, paddr, paddr_end, npages,
                  map_flags, input ready);
  modport sink   (input valid, req_type, vaddr, paddr, paddr_end, npages,
                  map_flags, output ready);
endinterface

interface ptmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

// File: hdl/page_table_map_translate.sv
// ----------------------------------------------------------------------------
// page_table_map_translate - flat 4 KiB page entry store with map and translate
// Identity init, range map, map-to-end, entry read and address translation.
// ----------------------------------------------------------------------------
// Usage: the store holds 2^VA_PAGE_BITS entries of {phys page, 12 flag bits}.
// After reset the block runs a clearing pass that writes the identity map,
// one entry per cycle: in_ch.ready stays low until the pass is done.
// One request is worked at a time; each gives exactly one response beat.
// Steps per request, from accept to ready again (a walk writes one entry
// per cycle through the single memory write port):
//   read entry / translate : accept issues the read, S_READ forms the data
//   rejected or unused code: S_DONE gives the status response
//   map range / map to end : S_WALK until done or out of range, then S_DONE
//   identity init          : S_WALK over the whole store, then S_DONE
// A finished response sits in an output register; the next request is taken
// while it waits, and that request only stalls at its own response step.
// Reads always follow the last write of the previous request, so no
// forwarding is needed.
// ----------------------------------------------------------------------------
module page_table_map_translate
  import ptmt_pkg::*;
#(
  parameter int unsigned VA_PAGE_BITS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  ptmt_req_if.sink   in_ch,
  ptmt_rsp_if.source out_ch
);

  localparam int unsigned Depth = 1 << VA_PAGE_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,   // post-reset identity fill
    S_WALK  = 5'b00100,   // map / init walk
    S_READ  = 5'b01000,   // read data returns
    S_DONE  = 5'b10000    // status-only response
  } state_t;

  state_t state_r, state_nxt;

  // request capture
  logic                     xlate_r, xlate_nxt;
  logic [PAGE_OFFSET_BITS-1:0] off_r, off_nxt;
  logic [STAT_W-1:0]        res_r, res_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]        out_data_r, out_data_nxt;

  // walker / memory hookup
  logic                     walk_load, walk_run;
  walk_cmd_t                walk_cmd;
  walk_stat_t               walk_stat;
  logic                     wr_en;
  logic [VA_PAGE_BITS-1:0]  wr_addr;
  logic [ADDR_W-1:0]        wr_data;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_data;

  // request decode
  logic                     acc;
  logic                     out_free;
  logic [VPN_W-1:0]         vpn_in;
  logic                     in_oob;
  logic                     va_mis, pa_mis, pe_mis, pe_lt;
  logic [VPN_W-1:0]         span;   // pages between start and end

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign vpn_in = in_ch.vaddr[ADDR_W-1:PAGE_OFFSET_BITS];
  assign in_oob = ({1'b0, vpn_in} >= CNT_W'(Depth));
  assign va_mis = |in_ch.vaddr[PAGE_OFFSET_BITS-1:0];
  assign pa_mis = |in_ch.paddr[PAGE_OFFSET_BITS-1:0];
  assign pe_mis = |in_ch.paddr_end[PAGE_OFFSET_BITS-1:0];
  assign pe_lt  = (in_ch.paddr_end < in_ch.paddr);
  // only used once both ends are aligned
  assign span   = in_ch.paddr_end[ADDR_W-1:PAGE_OFFSET_BITS]
                - in_ch.paddr[ADDR_W-1:PAGE_OFFSET_BITS];

  always_comb begin
    state_nxt      = state_r;
    xlate_nxt      = xlate_r;
    off_nxt        = off_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    walk_load      = 1'b0;
    walk_run       = 1'b0;
    rd_en          = 1'b0;

    walk_cmd.va_page = vpn_in;
    walk_cmd.pa_page = in_ch.paddr[ADDR_W-1:PAGE_OFFSET_BITS];
    walk_cmd.count   = CNT_W'(in_ch.npages);
    walk_cmd.flags   = in_ch.map_flags;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          xlate_nxt = (in_ch.req_type == REQ_XLATE);
          off_nxt   = in_ch.vaddr[PAGE_OFFSET_BITS-1:0];
          res_nxt   = STAT_OK;
          state_nxt = S_DONE;
          case (in_ch.req_type)
            REQ_INIT: begin
              walk_cmd.va_page = '0;
              walk_cmd.pa_page = '0;
              walk_cmd.count   = CNT_W'(Depth);
              walk_load        = 1'b1;
              state_nxt        = S_WALK;
            end
            REQ_MAP: begin
              // zero pages answers ok before any alignment check
              if (in_ch.npages != '0) begin
                if (va_mis || pa_mis) begin
                  res_nxt = STAT_BAD;
                end else begin
                  walk_load = 1'b1;
                  state_nxt = S_WALK;
                end
              end
            end
            REQ_MAP_TO: begin
              if (va_mis || pa_mis || pe_mis || pe_lt) begin
                res_nxt = STAT_BAD;
              end else begin
                walk_cmd.count = {1'b0, span};
                walk_load      = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            REQ_READ, REQ_XLATE: begin
              if (in_oob) begin
                res_nxt = STAT_RANGE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              // unused codes: ok, no change
            end
          endcase
        end
      end
      S_CLEAR: begin
        walk_run = 1'b1;
        if (walk_stat.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        walk_run = 1'b1;
        if (walk_stat.done) begin
          res_nxt   = STAT_OK;
          state_nxt = S_DONE;
        end else if (walk_stat.oob) begin
          // pages before this one stay written
          res_nxt   = STAT_RANGE;
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_data_nxt   = xlate_r ? {rd_data[ADDR_W-1:PAGE_OFFSET_BITS], off_r} : rd_data;
          state_nxt      = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_data_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xlate_r      <= xlate_nxt;
    off_r        <= off_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;

  ptmt_walker #(
    .VA_PAGE_BITS (VA_PAGE_BITS)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (walk_load),
    .cmd     (walk_cmd),
    .run     (walk_run),
    .stat    (walk_stat),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ptmt_store #(
    .VA_PAGE_BITS (VA_PAGE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (vpn_in[VA_PAGE_BITS-1:0]),
    .rd_data (rd_data)
  );

endmodule

// File: hdl/ptmt_store.sv
// ----------------------------------------------------------------------------
// ptmt_store - page entry memory
// One write port, one read port with registered read data (hold when idle).
// ----------------------------------------------------------------------------
module ptmt_store
  import ptmt_pkg::*;
#(
  parameter int unsigned VA_PAGE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [VA_PAGE_BITS-1:0] wr_addr,
  input  logic [ADDR_W-1:0]       wr_data,
  input  logic                    rd_en,
  input  logic [VA_PAGE_BITS-1:0] rd_addr,
  output logic [ADDR_W-1:0]       rd_data
);

  localparam int unsigned Depth = 1 << VA_PAGE_BITS;

  logic [ADDR_W-1:0] mem [Depth];
  logic [ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/ptmt_walker.sv
// ----------------------------------------------------------------------------
// ptmt_walker - page range walker
// Writes one entry per cycle while run is high, advancing virtual and physical pages together.
// ----------------------------------------------------------------------------
module ptmt_walker
  import ptmt_pkg::*;
#(
  parameter int unsigned VA_PAGE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  walk_cmd_t               cmd,
  input  logic                    run,
  output walk_stat_t              stat,
  output logic                    wr_en,
  output logic [VA_PAGE_BITS-1:0] wr_addr,
  output logic [ADDR_W-1:0]       wr_data
);

  localparam int unsigned Depth = 1 << VA_PAGE_BITS;

  logic [VPN_W-1:0]  va_r,  va_nxt;
  logic [VPN_W-1:0]  pa_r,  pa_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FLAG_W-1:0] flg_r, flg_nxt;

  always_comb begin
    stat.done = (cnt_r == '0);
    stat.oob  = ({1'b0, va_r} >= CNT_W'(Depth));
    wr_en     = run && !stat.done && !stat.oob;
    wr_addr   = va_r[VA_PAGE_BITS-1:0];
    wr_data   = {pa_r, flg_r};
  end

  always_comb begin
    va_nxt  = va_r;
    pa_nxt  = pa_r;
    cnt_nxt = cnt_r;
    flg_nxt = flg_r;
    if (load) begin
      va_nxt  = cmd.va_page;
      pa_nxt  = cmd.pa_page;
      cnt_nxt = cmd.count;
      flg_nxt = cmd.flags;
    end else if (wr_en) begin
      va_nxt  = va_r + 1'b1;
      pa_nxt  = pa_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // reset loads the identity clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= '0;
      pa_r  <= '0;
      cnt_r <= CNT_W'(Depth);
      flg_r <= '0;
    end else begin
      va_r  <= va_nxt;
      pa_r  <= pa_nxt;
      cnt_r <= cnt_nxt;
      flg_r <= flg_nxt;
    end
  end

endmodule

// File: sim/ptmt_checker.sv
// ----------------------------------------------------------------------------
// ptmt_checker - reply predictor and scoreboard for page_table_map_translate
// Watches both channels. Each accepted request beat updates a shadow copy of
// the page entry store and queues the reply it should produce. Each reply
// beat is compared against the oldest queued reply.
// ----------------------------------------------------------------------------
module ptmt_checker
  import ptmt_pkg::*;
#(
  parameter int unsigned VA_PAGE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ptmt_req_if         req_mon,
  ptmt_rsp_if         rsp_mon,
  output int unsigned fail_count,
  output int unsigned owed_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 1 << VA_PAGE_BITS;
  localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;
  localparam logic [31:0] BASE_MASK  = 32'hFFFF_F000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       data;
  } reply_t;

  logic [31:0] entry_shadow [DEPTH];
  reply_t      owed_q [$];
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [VPN_W-1:0] vpn_of(input logic [31:0] addr);
    return addr[31:PAGE_OFFSET_BITS];
  endfunction

  // store slot of an address already known to be in range
  function automatic logic [VA_PAGE_BITS-1:0] slot_of(input logic [31:0] addr);
    return addr[PAGE_OFFSET_BITS +: VA_PAGE_BITS];
  endfunction

  function automatic logic unaligned(input logic [31:0] addr);
    return addr[PAGE_OFFSET_BITS-1:0] != '0;
  endfunction

  function automatic void fill_identity(input logic [FLAG_W-1:0] flags);
    for (int unsigned i = 0; i < DEPTH; i++)
      entry_shadow[VA_PAGE_BITS'(i)] = (32'(i) << PAGE_OFFSET_BITS) | 32'(flags);
  endfunction

  // range walk: stops at the first page past the store, earlier writes stay
  function automatic logic [STAT_W-1:0] walk_pages(input logic [31:0] va,
                                                   input logic [31:0] pa,
                                                   input logic [31:0] pages,
                                                   input logic [FLAG_W-1:0] flags);
    logic [31:0] v;
    logic [31:0] p;
    v = va;
    p = pa;
    if (pages == 0) return STAT_OK;
    if (unaligned(va) || unaligned(pa)) return STAT_BAD;
    for (logic [31:0] n = 0; n < pages; n++) begin
      if (vpn_of(v) >= DEPTH) return STAT_RANGE;
      entry_shadow[slot_of(v)] = p | 32'(flags);
      v += PAGE_BYTES;
      p += PAGE_BYTES;
    end
    return STAT_OK;
  endfunction

  function automatic reply_t predict_reply(input logic [2:0]        op,
                                           input logic [31:0]       va,
                                           input logic [31:0]       pa,
                                           input logic [31:0]       pe,
                                           input logic [PCNT_W-1:0] cnt,
                                           input logic [FLAG_W-1:0] flags);
    reply_t r;
    r = '0;
    case (op)
      REQ_INIT: fill_identity(flags);
      REQ_MAP: r.status = walk_pages(va, pa, 32'(cnt), flags);
      REQ_MAP_TO: begin
        if (unaligned(va) || unaligned(pa) || unaligned(pe) || pe < pa)
          r.status = STAT_BAD;
        else
          r.status = walk_pages(va, pa, (pe - pa) >> PAGE_OFFSET_BITS, flags);
      end
      REQ_READ: begin
        if (vpn_of(va) >= DEPTH) r.status = STAT_RANGE;
        else r.data = entry_shadow[slot_of(va)];
      end
      REQ_XLATE: begin
        if (vpn_of(va) >= DEPTH) r.status = STAT_RANGE;
        else r.data = (entry_shadow[slot_of(va)] & BASE_MASK) + (va & ~BASE_MASK);
      end
      default: ;
    endcase
    return r;
  endfunction

  // replies are in order and always come after their request is accepted,
  // so the reply side is retired before the request side is queued
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      fill_identity('0);
      owed_q.delete();
      owed_count <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: reply beat with none expected: status %0d data %08h",
                   $time, rsp_mon.status, rsp_mon.data);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (rsp_mon.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp_mon.status);
            mismatches++;
          end
          if (rsp_mon.data !== want.data) begin
            $display("%0t: data mismatch: expected %08h actual %08h",
                     $time, want.data, rsp_mon.data);
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        owed_q.push_back(predict_reply(req_mon.req_type, req_mon.vaddr,
                                       req_mon.paddr, req_mon.paddr_end,
                                       req_mon.npages, req_mon.map_flags));
      owed_count <= owed_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench top for page_table_map_translate
// Drives request beats (a directed opener, then weighted random traffic),
// stalls the reply side on its own pattern, and reports the verdict from
// the checker's mismatch and owed-reply counts.
// ----------------------------------------------------------------------------
module tb_top
  import ptmt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VA_PAGE_BITS = 10;
  localparam int unsigned DEPTH        = 1 << VA_PAGE_BITS;
  localparam logic [31:0] PAGE_BYTES   = 32'h0000_1000;
  localparam logic [31:0] BASE_MASK    = 32'hFFFF_F000;
  localparam int unsigned RAND_ITEMS   = 1850;
  localparam int unsigned DRAIN_AT     = 600;   // random item after which the sender waits
  localparam int unsigned HOLD_CYCLES  = 400;   // long reply-side hold-off

  typedef struct packed {
    logic [2:0]        op;
    logic [31:0]       va;
    logic [31:0]       pa;
    logic [31:0]       pe;
    logic [PCNT_W-1:0] cnt;
    logic [FLAG_W-1:0] flags;
  } page_req_t;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned owed_count;

  // sender burst state
  int unsigned burst_left = 0;

  ptmt_req_if in_ch ();
  ptmt_rsp_if out_ch ();

  page_table_map_translate #(
    .VA_PAGE_BITS(VA_PAGE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ptmt_checker #(
    .VA_PAGE_BITS(VA_PAGE_BITS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (in_ch),
    .rsp_mon   (out_ch),
    .fail_count(fail_count),
    .owed_count(owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit. The slowest legal run is made up of the clearing pass,
  // a few dozen inits and large walks, plus stalls.
  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic page_req_t mk(input logic [2:0]        op,
                                   input logic [31:0]       va,
                                   input logic [31:0]       pa,
                                   input logic [31:0]       pe,
                                   input logic [PCNT_W-1:0] cnt,
                                   input logic [FLAG_W-1:0] flags);
    page_req_t r;
    r.op    = op;
    r.va    = va;
    r.pa    = pa;
    r.pe    = pe;
    r.cnt   = cnt;
    r.flags = flags;
    return r;
  endfunction

  // page-aligned address inside the store; sometimes pinned near its top end
  function automatic logic [31:0] store_page();
    if ($urandom_range(0, 9) == 0)
      return 32'($urandom_range(DEPTH - 16, DEPTH - 1)) << PAGE_OFFSET_BITS;
    return 32'($urandom_range(0, DEPTH - 1)) << PAGE_OFFSET_BITS;
  endfunction

  // lookup address: mostly in the store with any offset, some fully random
  function automatic logic [31:0] lookup_addr();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return store_page() | ($urandom() & ~BASE_MASK);
  endfunction

  // page counts skew small; a few long walks and raw 11-bit values
  function automatic int unsigned pick_pages();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(0, 8);
    if (k < 95) return $urandom_range(9, 64);
    if (k < 98) return $urandom_range(65, DEPTH);
    return $urandom_range(0, (1 << PCNT_W) - 1);
  endfunction

  function automatic page_req_t rand_req();
    page_req_t   r;
    int unsigned pick;
    int unsigned flaw;
    int unsigned span;
    pick    = $urandom_range(0, 99);
    flaw    = $urandom_range(0, 19);
    r.op    = REQ_READ;
    r.va    = store_page();
    r.pa    = $urandom() & BASE_MASK;
    r.pe    = $urandom();
    r.cnt   = '0;
    r.flags = FLAG_W'($urandom());
    if (pick < 28) begin
      r.va = lookup_addr();
    end else if (pick < 56) begin
      r.op = REQ_XLATE;
      r.va = lookup_addr();
    end else if (pick < 76) begin
      r.op  = REQ_MAP;
      r.cnt = PCNT_W'(pick_pages());
      case (flaw)
        0: r.va |= $urandom_range(1, PAGE_BYTES - 1);
        1: r.pa |= $urandom_range(1, PAGE_BYTES - 1);
        2: r.va = $urandom();
        default: ;
      endcase
    end else if (pick < 88) begin
      r.op = REQ_MAP_TO;
      span = pick_pages();
      r.pe = r.pa + (32'(span) << PAGE_OFFSET_BITS);  // may wrap: end below start
      case (flaw)
        0: r.pe |= $urandom_range(1, PAGE_BYTES - 1);
        1: r.pe = r.pa - (32'($urandom_range(1, 16)) << PAGE_OFFSET_BITS);
        2: r.pe = $urandom();
        3: r.va |= $urandom_range(1, PAGE_BYTES - 1);
        4: r.pa |= $urandom_range(1, PAGE_BYTES - 1);
        default: ;
      endcase
    end else if (pick < 91) begin
      r.op = REQ_INIT;
    end else if (pick < 95) begin
      r.op = 3'(REQ_XLATE + 1 + $urandom_range(0, 2));  // unused codes
    end else begin
      // raw noise over every field
      r.op  = 3'($urandom());
      r.va  = $urandom();
      r.pa  = $urandom();
      r.cnt = PCNT_W'($urandom());
    end
    return r;
  endfunction

  // Offer one request beat and hold it until taken. Between bursts valid drops
  // for a random gap; with drain set it stays low until no reply is owed.
  task automatic send_req(input page_req_t r, input bit drain);
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= r.op;
    in_ch.vaddr     <= r.va;
    in_ch.paddr     <= r.pa;
    in_ch.paddr_end <= r.pe;
    in_ch.npages    <= r.cnt;
    in_ch.map_flags <= r.flags;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0 || drain) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 10)) @(posedge clk);
      // owed_count is registered in the checker, so the value read here lags the queue
      if (drain) do @(posedge clk); while (owed_count != 0);
    end else begin
      burst_left--;
    end
  endtask

  // Reply side: stall mode changes every so often; after a set number of
  // reply beats it holds ready low for a long stretch so the block backs up.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beats;
    int unsigned hold_at;
    mode      = 0;
    mode_left = 0;
    beats     = 0;
    hold_at   = 150;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) beats++;
      if (beats >= hold_at) begin
        hold_at = (hold_at < 1000) ? 1000 : 32'hFFFF_FFFF;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;                          // no stalls
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    page_req_t opener [$];
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_INIT;
    in_ch.vaddr     <= '0;
    in_ch.paddr     <= '0;
    in_ch.paddr_end <= '0;
    in_ch.npages    <= '0;
    in_ch.map_flags <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset identity map, store edges, out-of-range pages
    opener.push_back(mk(REQ_READ,  32'h0000_0000, '0, '0, '0, '0));
    opener.push_back(mk(REQ_XLATE, 32'h003F_FFFF, '0, '0, '0, '0));
    opener.push_back(mk(REQ_READ,  32'h0040_0000, '0, '0, '0, '0));
    opener.push_back(mk(REQ_XLATE, 32'hFFFF_FFFF, '0, '0, '0, '0));
    // unused request codes
    for (int unsigned c = REQ_XLATE + 1; c < 8; c++)
      opener.push_back(mk(3'(c), $urandom(), $urandom(), $urandom(),
                          PCNT_W'($urandom()), FLAG_W'($urandom())));
    // init with all flags, read with offset bits ignored
    opener.push_back(mk(REQ_INIT,  '0, '0, '0, '0, 12'hFFF));
    opener.push_back(mk(REQ_READ,  32'h0000_5FFF, '0, '0, '0, '0));
    // zero-page range answers ok even misaligned; misaligned va / pa
    opener.push_back(mk(REQ_MAP, 32'h0000_1234, 32'h0000_0567, '0, '0, 12'h111));
    opener.push_back(mk(REQ_MAP, 32'h0000_1004, 32'h0000_2000, '0, 11'd1, 12'h111));
    opener.push_back(mk(REQ_MAP, 32'h0000_1000, 32'h0000_2800, '0, 11'd1, 12'h111));
    // walk runs off the store end; physical address wraps mid-walk
    opener.push_back(mk(REQ_MAP, 32'h003F_E000, 32'hFFFF_E000, '0, 11'd4, 12'hABC));
    opener.push_back(mk(REQ_MAP, 32'h003F_0000, 32'hFFFF_F000, '0, 11'd3, 12'h5A5));
    opener.push_back(mk(REQ_XLATE, 32'h003F_F7FF, '0, '0, '0, '0));
    opener.push_back(mk(REQ_READ,  32'h003F_1000, '0, '0, '0, '0));
    // largest raw count from page 0: fills the store then hits range
    opener.push_back(mk(REQ_MAP, '0, 32'h8000_0000, '0, 11'h7FF, 12'h000));
    // map-to: end misaligned, end below start, empty, va misaligned, good
    opener.push_back(mk(REQ_MAP_TO, 32'h0000_3000, 32'h0010_0000, 32'h0010_2001, '0, 12'h7));
    opener.push_back(mk(REQ_MAP_TO, 32'h0000_3000, 32'h0010_0000, 32'h000F_F000, '0, 12'h7));
    opener.push_back(mk(REQ_MAP_TO, 32'h0000_3000, 32'h0010_0000, 32'h0010_0000, '0, 12'h7));
    opener.push_back(mk(REQ_MAP_TO, 32'h0000_3010, 32'h0010_0000, 32'h0010_3000, '0, 12'h7));
    opener.push_back(mk(REQ_MAP_TO, 32'h0000_3000, 32'h0010_0000, 32'h0010_3000, '0, 12'h7));
    // huge span from near the store end stops at range
    opener.push_back(mk(REQ_MAP_TO, 32'h003F_D000, '0, 32'hFFFF_F000, '0, 12'h800));
    opener.push_back(mk(REQ_XLATE, 32'h0000_4ABC, '0, '0, '0, '0));
    // exactly the whole store, then back to a plain identity map
    opener.push_back(mk(REQ_MAP,  '0, 32'h1234_5000, '0, 11'd1024, 12'h0F0));
    opener.push_back(mk(REQ_INIT, '0, '0, '0, '0, 12'h000));

    foreach (opener[i]) send_req(opener[i], 1'b0);

    for (int unsigned i = 0; i < RAND_ITEMS; i++)
      send_req(rand_req(), (i == DRAIN_AT) || (i == RAND_ITEMS - 1));

    // last send drained the reply queue; let any trailing beat show up
    repeat (20) @(posedge clk);
    if (fail_count == 0 && owed_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ptmt_pkg.sv
hdl/ptmt_if.sv
hdl/ptmt_store.sv
hdl/ptmt_walker.sv
hdl/page_table_map_translate.sv
sim/ptmt_checker.sv
sim/tb_top.sv
